// ----- sv/eight_bit_alu_with_flags_unit_macros.svh -----
// Assertion macros for the eight-bit ALU block and its checker.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_UNIT_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define EBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("eba assertion failed");

// Next-cycle implication, checked outside reset
`define EBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("eba assertion failed");

// Next-cycle implication, checked in reset as well
`define EBA_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("eba assertion failed");

`endif

// ----- sv/eba_pkg.sv -----
// Shared types and constants of the eight-bit ALU with flags.
`timescale 1ns / 1ps
`default_nettype none

package eba_pkg;

    // Operation codes
    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLCA  = 5'd10,
        OP_RRCA  = 5'd11,
        OP_RLA   = 5'd12,
        OP_RRA   = 5'd13,
        OP_DAA   = 5'd14,
        OP_CPL   = 5'd15,
        OP_SCF   = 5'd16,
        OP_CCF   = 5'd17,
        OP_ADD16 = 5'd18
    } t_alu_op;

    // Flag bit positions
    localparam int unsigned FLAG_C  = 0;
    localparam int unsigned FLAG_N  = 1;
    localparam int unsigned FLAG_PV = 2;
    localparam int unsigned FLAG_H  = 4;
    localparam int unsigned FLAG_Z  = 6;

    // Flag masks
    localparam logic [7:0] MASK_SZ53 = 8'hA8;  // sign and undocumented bits
    localparam logic [7:0] MASK_53   = 8'h28;  // undocumented bits 5 and 3
    localparam logic [7:0] MASK_53C  = 8'h29;  // bits 5, 3 and carry
    localparam logic [7:0] MASK_SZPV = 8'hC4;  // sign, zero, parity/overflow
    localparam logic [7:0] MASK_SZPC = 8'hC5;  // sign, zero, parity/overflow, carry
    localparam logic [7:0] MASK_NOPV = 8'hFB;  // all but parity/overflow
    localparam logic [7:0] MASK_HN   = 8'h12;  // half carry and subtract

    // One input item
    typedef struct packed {
        logic [15:0] pair_addend;
        logic [15:0] pair_in;
        logic [7:0]  flags_in;
        logic [7:0]  operand;
        logic [7:0]  acc_in;
        logic [4:0]  operation;
    } t_alu_req;

    // One result item
    typedef struct packed {
        logic [15:0] pair_out;
        logic [7:0]  flags_out;
        logic [7:0]  result;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ----- sv/eba_alu.sv -----
// Combinational datapath of the eight-bit ALU: result, flag byte and pair.
`timescale 1ns / 1ps
`default_nettype none

module eba_alu
    import eba_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] res;
    } t_arith;

    // 8-bit add with carry in and full flag set
    function automatic t_arith add8(input logic [7:0] a, input logic [7:0] z,
                                    input logic c);
        logic [8:0] y;
        logic [4:0] h;
        t_arith     o;
        y = {1'b0, a} + {1'b0, z} + {8'b0, c};
        h = {1'b0, a[3:0]} + {1'b0, z[3:0]} + {4'b0, c};
        o.res = y[7:0];
        o.flags = (y[7:0] & MASK_SZ53) | {7'b0, y[8]};
        o.flags[FLAG_H]  = h[4];
        o.flags[FLAG_PV] = ~(a[7] ^ z[7]) & (y[7] ^ a[7]);
        o.flags[FLAG_Z]  = (y[7:0] == 8'h00);
        return o;
    endfunction

    // 8-bit subtract with borrow in and full flag set
    function automatic t_arith sub8(input logic [7:0] a, input logic [7:0] z,
                                    input logic c);
        logic [8:0] y;
        t_arith     o;
        y = {1'b0, a} - {1'b0, z} - {8'b0, c};
        o.res = y[7:0];
        o.flags = (y[7:0] & MASK_SZ53) | {7'b0, y[8]};
        o.flags[FLAG_N]  = 1'b1;
        o.flags[FLAG_H]  = {1'b0, a[3:0]} < ({1'b0, z[3:0]} + {4'b0, c});
        o.flags[FLAG_PV] = (a[7] ^ z[7]) & (y[7] ^ a[7]);
        o.flags[FLAG_Z]  = (y[7:0] == 8'h00);
        return o;
    endfunction

    always_comb begin
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] f;
        logic       cy;
        logic [7:0] r;
        logic [7:0] incr;
        logic [8:0] lo;
        logic [8:0] hi;
        logic [4:0] hn;
        t_arith     ar;

        a    = i_req.acc_in;
        x    = i_req.operand;
        f    = i_req.flags_in;
        cy   = f[FLAG_C];
        r    = 8'h00;
        incr = 8'h00;
        lo   = 9'h000;
        hi   = 9'h000;
        hn   = 5'h00;
        ar   = '0;

        // unused codes pass everything through
        o_rsp.result    = a;
        o_rsp.flags_out = f;
        o_rsp.pair_out  = i_req.pair_in;

        unique case (t_alu_op'(i_req.operation))
            OP_ADD, OP_ADC: begin
                ar = add8(a, x, (i_req.operation == OP_ADC) ? cy : 1'b0);
                o_rsp.result    = ar.res;
                o_rsp.flags_out = ar.flags;
            end
            OP_SUB, OP_SBC: begin
                ar = sub8(a, x, (i_req.operation == OP_SBC) ? cy : 1'b0);
                o_rsp.result    = ar.res;
                o_rsp.flags_out = ar.flags;
            end
            OP_CP: begin
                // flags of the difference, accumulator unchanged
                ar = sub8(a, x, 1'b0);
                o_rsp.flags_out = ar.flags;
            end
            OP_AND, OP_XOR, OP_OR: begin
                if (i_req.operation == OP_AND) begin
                    r = a & x;
                end else if (i_req.operation == OP_XOR) begin
                    r = a ^ x;
                end else begin
                    r = a | x;
                end
                o_rsp.result    = r;
                o_rsp.flags_out = r & MASK_SZ53;
                o_rsp.flags_out[FLAG_Z] = (r == 8'h00);
                o_rsp.flags_out[FLAG_H] = (i_req.operation == OP_AND);
            end
            OP_INC: begin
                r = x + 8'd1;
                o_rsp.result    = r;
                o_rsp.flags_out = (r & MASK_SZ53) | {7'b0, cy};
                o_rsp.flags_out[FLAG_H]  = (r[3:0] == 4'h0);
                o_rsp.flags_out[FLAG_Z]  = (r == 8'h00);
                o_rsp.flags_out[FLAG_PV] = (r == 8'h80);
            end
            OP_DEC: begin
                r = x - 8'd1;
                o_rsp.result    = r;
                o_rsp.flags_out = (r & MASK_SZ53) | {7'b0, cy};
                o_rsp.flags_out[FLAG_N]  = 1'b1;
                o_rsp.flags_out[FLAG_H]  = (x[3:0] == 4'h0);
                o_rsp.flags_out[FLAG_Z]  = (r == 8'h00);
                o_rsp.flags_out[FLAG_PV] = (r == 8'h7F);
            end
            OP_RLCA: begin
                r = {a[6:0], a[7]};
                o_rsp.result    = r;
                o_rsp.flags_out = (f & MASK_SZPV) | (r & MASK_53C);
            end
            OP_RRCA: begin
                r = {a[0], a[7:1]};
                o_rsp.result    = r;
                o_rsp.flags_out = (f & MASK_SZPV) | (r & MASK_53) | {7'b0, a[0]};
            end
            OP_RLA: begin
                r = {a[6:0], cy};
                o_rsp.result    = r;
                o_rsp.flags_out = (f & MASK_SZPV) | (r & MASK_53) | {7'b0, a[7]};
            end
            OP_RRA: begin
                r = {cy, a[7:1]};
                o_rsp.result    = r;
                o_rsp.flags_out = (f & MASK_SZPV) | (r & MASK_53) | {7'b0, a[0]};
            end
            OP_DAA: begin
                // pick the correction from H, C and the two nibbles
                if (f[FLAG_H] || (a[3:0] > 4'd9)) begin
                    incr[3:0] = 4'h6;
                end
                if (cy || (a[7:4] > 4'd9)) begin
                    incr[7:4] = 4'h6;
                end
                if (f[FLAG_N]) begin
                    ar = sub8(a, incr, 1'b0);
                end else begin
                    if ((a > 8'h90) && (a[3:0] > 4'd9)) begin
                        incr[7:4] = 4'h6;
                    end
                    ar = add8(a, incr, 1'b0);
                end
                o_rsp.result    = ar.res;
                o_rsp.flags_out = (ar.flags | {7'b0, cy}) & MASK_NOPV;
            end
            OP_CPL: begin
                r = ~a;
                o_rsp.result    = r;
                o_rsp.flags_out = (f & MASK_SZPC) | (r & MASK_53) | MASK_HN;
            end
            OP_SCF: begin
                o_rsp.flags_out = (f & MASK_SZPV) | (a & MASK_53) | 8'h01;
            end
            OP_CCF: begin
                o_rsp.flags_out = (f & MASK_SZPV) | (a & MASK_53) | {7'b0, ~cy};
                o_rsp.flags_out[FLAG_H] = cy;
            end
            OP_ADD16: begin
                // low byte, then high byte with half carry out of bit 11
                lo = {1'b0, i_req.pair_in[7:0]} + {1'b0, i_req.pair_addend[7:0]};
                hi = {1'b0, i_req.pair_in[15:8]} + {1'b0, i_req.pair_addend[15:8]}
                   + {8'b0, lo[8]};
                hn = {1'b0, i_req.pair_in[11:8]} + {1'b0, i_req.pair_addend[11:8]}
                   + {4'b0, lo[8]};
                o_rsp.flags_out = (f & MASK_SZPV) | (hi[7:0] & MASK_53) | {7'b0, hi[8]};
                o_rsp.flags_out[FLAG_H] = hn[4];
                o_rsp.pair_out = {hi[7:0], lo[7:0]};
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/eight_bit_alu_with_flags_unit.sv -----
// Top level of the eight-bit ALU with flags: input register, datapath, result register.
`timescale 1ns / 1ps
`default_nettype none

// Eight-bit ALU with Z80-style flags (S Z 5 H 3 P/V N C from bit 7 down) and a
// 16-bit pair add. No state is kept between items. An item is taken into the
// input register, goes through one combinational pass of the datapath and
// lands in the result register, and the block takes one new item in every
// cycle while the output is not stalled. Only the output side holds the flow:
// when the result register is held by a stalled consumer, the input register
// fills and then input ready drops.
module eight_bit_alu_with_flags_unit
    import eba_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [4:0] operation, [12:5] acc_in, [20:13] operand, [28:21] flags_in,
    // [44:29] pair_in, [60:45] pair_addend, [63:61] zero
    input  wire  [63:0] i_s_axis_tdata,
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [7:0] result, [15:8] flags_out, [31:16] pair_out
    output logic [31:0] o_m_axis_tdata
);

    t_alu_req r_req;
    logic     r_req_vld;
    t_alu_rsp r_rsp;
    logic     r_rsp_vld;
    t_alu_rsp n_rsp;
    logic     w_adv;

    // stage moves forward when the result register is free or being taken
    assign w_adv           = !r_rsp_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_req_vld || w_adv;

    // datapath
    eba_alu u_alu (
        .i_req (r_req),
        .o_rsp (n_rsp)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_req_vld <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_rsp_vld <= r_req_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_req <= t_alu_req'(i_s_axis_tdata[60:0]);
        end
        if (w_adv && r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_m_axis_tvalid = r_rsp_vld;
    assign o_m_axis_tdata  = r_rsp;

endmodule

`default_nettype wire

// ----- sv/eba_checker.sv -----
// Port-level checker for the eight-bit ALU, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "eight_bit_alu_with_flags_unit_macros.svh"

module eba_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire [63:0] i_s_axis_tdata,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [31:0] o_m_axis_tdata
);

    // a held result keeps its value
    `EBA_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // nothing comes out right after reset
    `EBA_ASSERT_ALWAYS(a_rst, !i_rst_n, !o_m_axis_tvalid)

    // with the output free the input is never blocked
    `EBA_ASSERT_NOW(a_rdy, !o_m_axis_tvalid || i_m_axis_tready, o_s_axis_tready)

    // an accepted item moves through the input register to the output when the consumer is ready
    `EBA_ASSERT_NEXT(a_lat, (i_s_axis_tvalid && o_s_axis_tready) ##1 i_m_axis_tready, o_m_axis_tvalid)

endmodule

bind eight_bit_alu_with_flags_unit eba_checker u_eba_checker (.*);

`default_nettype wire

// ----- bench/tb_eight_bit_alu_with_flags_unit.sv -----
// Self-checking stream bench for the eight-bit ALU with flags, directed table plus random items.
`timescale 1ns / 1ps

module tb_eight_bit_alu_with_flags_unit;
    import eba_pkg::*;

    // Highest code, outside the defined operations; must leave everything unchanged
    localparam logic [4:0] OP_UNUSED_TOP = 5'd31;
    localparam int unsigned RANDOM_ITEMS = 650;
    localparam int unsigned IDLE_PCT     = 25;

    // Directed stimulus row; typed expectation used when has_exp is set
    typedef struct {
        t_alu_req req;
        bit       has_exp;
        t_alu_rsp exp;
    } t_alu_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [63:0] in_data = '0;
    t_alu_rsp    in_expect = '0;
    logic        out_ready = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [31:0] out_data;

    t_alu_row    directed_rows[$];
    t_alu_rsp    results_due[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;

    eight_bit_alu_with_flags_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // 8-bit add with carry in; returns {flags, sum}
    function automatic logic [15:0] add_with_flags(input logic [7:0] a, input logic [7:0] z,
                                                   input logic c);
        logic [8:0] y;
        logic [7:0] fl;
        y  = {1'b0, a} + {1'b0, z} + {8'd0, c};
        fl = (y[7:0] & MASK_SZ53) | {7'd0, y[8]};
        if ({1'b0, a[3:0]} + {1'b0, z[3:0]} + {4'd0, c} > 5'd15) fl[FLAG_H] = 1'b1;
        if ((a[7] == z[7]) && (y[7] != a[7])) fl[FLAG_PV] = 1'b1;
        if (y[7:0] == 8'd0) fl[FLAG_Z] = 1'b1;
        return {fl, y[7:0]};
    endfunction

    // 8-bit subtract with borrow in; returns {flags, difference}
    function automatic logic [15:0] sub_with_flags(input logic [7:0] a, input logic [7:0] z,
                                                   input logic c);
        logic [8:0] y;
        logic [7:0] fl;
        y  = {1'b0, a} - {1'b0, z} - {8'd0, c};
        fl = (y[7:0] & MASK_SZ53) | {7'd0, y[8]};
        fl[FLAG_N] = 1'b1;
        if ({1'b0, a[3:0]} < {1'b0, z[3:0]} + {4'd0, c}) fl[FLAG_H] = 1'b1;
        if ((a[7] != z[7]) && (y[7] != a[7])) fl[FLAG_PV] = 1'b1;
        if (y[7:0] == 8'd0) fl[FLAG_Z] = 1'b1;
        return {fl, y[7:0]};
    endfunction

    // Result of one ALU operation
    function automatic t_alu_rsp alu_outcome(input t_alu_req req);
        t_alu_rsp   rsp;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] f;
        logic       cy;
        logic [7:0] r;
        logic [7:0] nf;
        logic [7:0] incr;
        logic [15:0] rf;
        logic [8:0] lo;
        logic [8:0] hi;
        a  = req.acc_in;
        x  = req.operand;
        f  = req.flags_in;
        cy = f[FLAG_C];
        r  = a;
        nf = f;
        rsp.pair_out = req.pair_in;
        case (req.operation)
            OP_ADD: begin
                rf = add_with_flags(a, x, 1'b0);
                {nf, r} = rf;
            end
            OP_ADC: begin
                rf = add_with_flags(a, x, cy);
                {nf, r} = rf;
            end
            OP_SUB: begin
                rf = sub_with_flags(a, x, 1'b0);
                {nf, r} = rf;
            end
            OP_SBC: begin
                rf = sub_with_flags(a, x, cy);
                {nf, r} = rf;
            end
            OP_AND, OP_XOR, OP_OR: begin
                if (req.operation == OP_AND) r = a & x;
                else if (req.operation == OP_XOR) r = a ^ x;
                else r = a | x;
                // no parity: P/V stays clear
                nf = r & MASK_SZ53;
                nf[FLAG_Z] = (r == 8'd0);
                nf[FLAG_H] = (req.operation == OP_AND);
            end
            OP_CP: begin
                rf = sub_with_flags(a, x, 1'b0);
                nf = rf[15:8];
            end
            OP_INC: begin
                r  = x + 8'd1;
                nf = r & MASK_SZ53;
                nf[FLAG_C]  = cy;
                nf[FLAG_H]  = (r[3:0] == 4'd0);
                nf[FLAG_Z]  = (r == 8'd0);
                nf[FLAG_PV] = (r == 8'h80);
            end
            OP_DEC: begin
                r  = x - 8'd1;
                nf = r & MASK_SZ53;
                nf[FLAG_C]  = cy;
                nf[FLAG_N]  = 1'b1;
                nf[FLAG_H]  = (x[3:0] == 4'd0);
                nf[FLAG_Z]  = (r == 8'd0);
                nf[FLAG_PV] = (r == 8'h7f);
            end
            OP_RLCA: begin
                r  = {a[6:0], a[7]};
                nf = (f & MASK_SZPV) | (r & MASK_53C);
            end
            OP_RRCA: begin
                r  = {a[0], a[7:1]};
                nf = (f & MASK_SZPV) | (r & MASK_53);
                nf[FLAG_C] = a[0];
            end
            OP_RLA: begin
                r  = {a[6:0], cy};
                nf = (f & MASK_SZPV) | (r & MASK_53);
                nf[FLAG_C] = a[7];
            end
            OP_RRA: begin
                r  = {cy, a[7:1]};
                nf = (f & MASK_SZPV) | (r & MASK_53);
                nf[FLAG_C] = a[0];
            end
            OP_DAA: begin
                incr = 8'd0;
                if (f[FLAG_H] || a[3:0] > 4'd9) incr = 8'h06;
                if (cy || a[7:4] > 4'd9) incr = incr | 8'h60;
                if (f[FLAG_N]) begin
                    rf = sub_with_flags(a, incr, 1'b0);
                end else begin
                    if (a > 8'h90 && a[3:0] > 4'd9) incr = incr | 8'h60;
                    rf = add_with_flags(a, incr, 1'b0);
                end
                {nf, r} = rf;
                // carry is sticky, overflow always cleared
                nf[FLAG_C] = nf[FLAG_C] | cy;
                nf = nf & MASK_NOPV;
            end
            OP_CPL: begin
                r  = ~a;
                nf = (f & MASK_SZPC) | (r & MASK_53) | MASK_HN;
            end
            OP_SCF: begin
                nf = (f & MASK_SZPV) | (a & MASK_53);
                nf[FLAG_C] = 1'b1;
            end
            OP_CCF: begin
                nf = (f & MASK_SZPV) | (a & MASK_53);
                nf[FLAG_C] = ~cy;
                nf[FLAG_H] = cy;
            end
            OP_ADD16: begin
                lo = {1'b0, req.pair_in[7:0]} + {1'b0, req.pair_addend[7:0]};
                hi = {1'b0, req.pair_in[15:8]} + {1'b0, req.pair_addend[15:8]} + {8'd0, lo[8]};
                nf = f & MASK_SZPV;
                nf[FLAG_H] = ({1'b0, req.pair_in[11:8]} + {1'b0, req.pair_addend[11:8]}
                              + {4'd0, lo[8]}) > 5'd15;
                nf = nf | (hi[7:0] & MASK_53);
                nf[FLAG_C] = hi[8];
                rsp.pair_out = {hi[7:0], lo[7:0]};
            end
            default: begin
            end
        endcase
        rsp.result    = r;
        rsp.flags_out = nf;
        return rsp;
    endfunction

    // One directed row
    task automatic add_row(input logic [4:0] op, input logic [7:0] a, input logic [7:0] x,
                           input logic [7:0] f, input logic [15:0] p, input logic [15:0] q,
                           input bit has_exp, input logic [7:0] r, input logic [7:0] fo);
        t_alu_row row;
        row.req.operation   = op;
        row.req.acc_in      = a;
        row.req.operand     = x;
        row.req.flags_in    = f;
        row.req.pair_in     = p;
        row.req.pair_addend = q;
        row.has_exp         = has_exp;
        row.exp.result      = r;
        row.exp.flags_out   = fo;
        row.exp.pair_out    = p;
        directed_rows.push_back(row);
    endtask

    // Byte with extra weight on the edge values
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 19))
            0: v = 8'h00;
            1: v = 8'hff;
            2: v = 8'h7f;
            3: v = 8'h80;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Random item, mostly defined operations
    function automatic t_alu_req random_request();
        t_alu_req req;
        if ($urandom_range(0, 9) == 0) req.operation = 5'($urandom_range(19, 31));
        else req.operation = 5'($urandom_range(0, 18));
        req.acc_in   = pick_byte();
        req.operand  = pick_byte();
        req.flags_in = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
            req.pair_in     = 16'hffff;
            req.pair_addend = 16'($urandom_range(0, 65535));
        end else begin
            req.pair_in     = 16'($urandom_range(0, 65535));
            req.pair_addend = 16'($urandom_range(0, 65535));
        end
        return req;
    endfunction

    // Offer one item, with an optional random gap in front
    task automatic offer_item(input t_alu_req req, input t_alu_rsp exp, input bit no_gap);
        if (!no_gap) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        in_data   <= {3'b000, req};
        in_expect <= exp;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp);
        $display("MISMATCH item %0d %s: got %h expected %h", results_seen, what, got, exp);
        mismatch_count++;
    endtask

    // Result checker and expectation capture
    always @(posedge clk) begin : result_check
        t_alu_rsp got_rsp;
        t_alu_rsp due_rsp;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got_rsp = t_alu_rsp'(out_data);
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result", got_rsp[15:0], 16'd0);
                end else begin
                    due_rsp = results_due.pop_front();
                    if (got_rsp.result != due_rsp.result)
                        report_mismatch("result", {8'd0, got_rsp.result},
                                        {8'd0, due_rsp.result});
                    if (got_rsp.flags_out != due_rsp.flags_out)
                        report_mismatch("flags_out", {8'd0, got_rsp.flags_out},
                                        {8'd0, due_rsp.flags_out});
                    if (got_rsp.pair_out != due_rsp.pair_out)
                        report_mismatch("pair_out", got_rsp.pair_out, due_rsp.pair_out);
                end
                results_seen++;
            end
            if (in_valid && in_ready) results_due.push_back(in_expect);
        end
    end

    // Result side: random stalls, one long hold-off, one stretch always ready
    initial begin : result_ready_drive
        int unsigned rx_cycle;
        rx_cycle = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (rx_cycle >= 150 && rx_cycle < 270) out_ready <= 1'b0;
            else if (rx_cycle >= 600 && rx_cycle < 900) out_ready <= 1'b1;
            else out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            rx_cycle++;
            @(posedge clk);
        end
    end

    // Reset, stimulus and end of run
    initial begin : stimulus
        t_alu_req req;
        t_alu_rsp exp;
        // add: zero, carry with half carry, signed overflow
        add_row(OP_ADD,  8'h00, 8'h00, 8'h00, 16'h1234, 16'h0001, 1'b1, 8'h00, 8'h40);
        add_row(OP_ADD,  8'hff, 8'h01, 8'h00, 16'hffff, 16'hffff, 1'b1, 8'h00, 8'h51);
        add_row(OP_ADD,  8'h7f, 8'h01, 8'hff, 16'h0000, 16'h0000, 1'b1, 8'h80, 8'h94);
        add_row(OP_ADC,  8'hff, 8'hff, 8'h01, 16'h8000, 16'h8000, 1'b0, 8'h00, 8'h00);
        // sub: borrow from zero
        add_row(OP_SUB,  8'h00, 8'h01, 8'h00, 16'h5a5a, 16'ha5a5, 1'b1, 8'hff, 8'hbb);
        add_row(OP_SBC,  8'h80, 8'h00, 8'h01, 16'h0001, 16'hfffe, 1'b0, 8'h00, 8'h00);
        // logic ops, P/V never set
        add_row(OP_AND,  8'hff, 8'h00, 8'hff, 16'h00ff, 16'hff00, 1'b1, 8'h00, 8'h50);
        add_row(OP_XOR,  8'hff, 8'hff, 8'h00, 16'hffff, 16'h0000, 1'b1, 8'h00, 8'h40);
        add_row(OP_OR,   8'h80, 8'h00, 8'h04, 16'h7fff, 16'h0001, 1'b1, 8'h80, 8'h80);
        // compare: bits 5 and 3 from the difference, accumulator kept
        add_row(OP_CP,   8'h28, 8'h00, 8'h00, 16'h0000, 16'hffff, 1'b0, 8'h00, 8'h00);
        // inc and dec: overflow points and wrap to zero, carry kept
        add_row(OP_INC,  8'h00, 8'h7f, 8'h01, 16'h1111, 16'h2222, 1'b1, 8'h80, 8'h95);
        add_row(OP_INC,  8'h55, 8'hff, 8'h00, 16'h3333, 16'h4444, 1'b1, 8'h00, 8'h50);
        add_row(OP_DEC,  8'haa, 8'h80, 8'h00, 16'h5555, 16'h6666, 1'b1, 8'h7f, 8'h3e);
        add_row(OP_DEC,  8'hff, 8'h01, 8'h00, 16'h7777, 16'h8888, 1'b1, 8'h00, 8'h42);
        // rotates
        add_row(OP_RLCA, 8'h80, 8'h00, 8'hff, 16'h9999, 16'haaaa, 1'b0, 8'h00, 8'h00);
        add_row(OP_RRCA, 8'h01, 8'h00, 8'h00, 16'hbbbb, 16'hcccc, 1'b0, 8'h00, 8'h00);
        add_row(OP_RLA,  8'h80, 8'h00, 8'h00, 16'hdddd, 16'heeee, 1'b0, 8'h00, 8'h00);
        add_row(OP_RRA,  8'h01, 8'h00, 8'h01, 16'h0f0f, 16'hf0f0, 1'b0, 8'h00, 8'h00);
        // decimal adjust after add, and after subtract with H and C set
        add_row(OP_DAA,  8'h9a, 8'h00, 8'h00, 16'h1357, 16'h2468, 1'b0, 8'h00, 8'h00);
        add_row(OP_DAA,  8'hff, 8'h00, 8'h13, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h00);
        add_row(OP_CPL,  8'h00, 8'h00, 8'hff, 16'hffff, 16'hffff, 1'b0, 8'h00, 8'h00);
        add_row(OP_SCF,  8'h00, 8'hff, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'h00, 8'h01);
        add_row(OP_CCF,  8'hff, 8'h00, 8'h01, 16'h8001, 16'h7fff, 1'b0, 8'h00, 8'h00);
        // 16-bit add: carry out of bit 15 and bit 11
        add_row(OP_ADD16, 8'h3c, 8'h00, 8'hff, 16'hffff, 16'h0001, 1'b0, 8'h00, 8'h00);
        // unused code: pass-through
        add_row(OP_UNUSED_TOP, 8'ha5, 8'h5a, 8'hc3, 16'hbeef, 16'h1234, 1'b1, 8'ha5, 8'hc3);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].has_exp) exp = directed_rows[i].exp;
            else exp = alu_outcome(directed_rows[i].req);
            offer_item(directed_rows[i].req, exp, 1'b0);
        end

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            req = random_request();
            offer_item(req, alu_outcome(req), (n >= 300 && n < 420));
        end
        in_valid <= 1'b0;
        // let the checker log the last accepted item
        @(posedge clk);

        // drain, then wait for anything stray
        while (results_due.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- eight_bit_alu_with_flags_unit.f -----
+incdir+sv
sv/eba_pkg.sv
sv/eba_alu.sv
sv/eight_bit_alu_with_flags_unit.sv
sv/eba_checker.sv
bench/tb_eight_bit_alu_with_flags_unit.sv
